// ===== rtl/core/wmcd_pkg.sv =====
package wmcd_pkg;

    // Field widths of the sample, the result and the configuration registers.
    localparam int COST_W  = 32;
    localparam int COUNT_W = 16;
    localparam int BAND_W  = 16;

    // (n-1)*old is COST_W+COUNT_W bits wide; adding the sample needs one more.
    localparam int PROD_W = COST_W + COUNT_W;
    localparam int NUM_W  = PROD_W + 1;
    // Band products (2^16 +/- eps) * old are COST_W+BAND_W+1 bits wide.
    localparam int BAND_PROD_W = COST_W + BAND_W + 1;

    localparam int MUL_STEPS = COUNT_W;
    localparam int DIV_STEPS = NUM_W;

    localparam int OUT_DATA_W = 48;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE   = 1'b0,
        CFG_BAND_FRACTION = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_BAND = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // Handshake between the sequencer and an iterative unit.
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/core/wmcd_mul.sv =====
module wmcd_mul (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wmcd_pkg::unit_ctrl_t                   ctrl,
    input  logic [wmcd_pkg::COST_W-1:0]            multiplicand,
    input  logic [wmcd_pkg::COUNT_W-1:0]           multiplier,
    output wmcd_pkg::unit_stat_t                   stat,
    output logic [wmcd_pkg::PROD_W-1:0]            product
);
    import wmcd_pkg::*;

    localparam int STEP_W = $clog2(MUL_STEPS);

    // Shift-and-add, one multiplier bit per cycle. The multiplier sits in the
    // low bits of the product register and is shifted out as partial sums
    // shift in from the top.
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [COST_W-1:0] mcand_reg, mcand_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [COST_W:0]   partial;

    always_comb begin
        partial    = {1'b0, prod_reg[PROD_W-1:COUNT_W]};
        if (prod_reg[0]) begin
            partial = partial + {1'b0, mcand_reg};
        end
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start) begin
            prod_next  = {{COST_W{1'b0}}, multiplier};
            mcand_next = multiplicand;
            step_next  = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            prod_next = {partial, prod_reg[COUNT_W-1:1]};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign product   = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/wmcd_div.sv =====
module wmcd_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wmcd_pkg::unit_ctrl_t                   ctrl,
    input  logic [wmcd_pkg::NUM_W-1:0]             numerator,
    input  logic [wmcd_pkg::COUNT_W-1:0]           divisor,
    output wmcd_pkg::unit_stat_t                   stat,
    output logic [wmcd_pkg::COST_W-1:0]            quotient
);
    import wmcd_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    // Restoring division, one quotient bit per cycle. Quotient bits shift in
    // at the bottom of the numerator register as numerator bits leave the top.
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        diff      = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            num_next  = numerator;
            rem_next  = '0;
            div_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = {num_reg[NUM_W-2:0], fits};
            rem_next  = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // The quotient never exceeds the larger of the old mean and the sample.
    assign quotient  = num_reg[COST_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/windowed_mean_convergence_detector_core.sv =====
// Windowed running-mean convergence detector. Every sample transfer on the
// s_ channel carries one unsigned Q16.16 cost and yields exactly one result
// transfer on the m_ channel with the updated running mean, the sample count
// and a sticky converged flag. The count saturates at window_size (a window of
// zero acts as one), the mean becomes ((n-1)*old + sample)/n truncated, and
// the flag sets once the count equals the window and the new mean lies
// strictly inside the band old*(1 -/+ band_fraction/2^16), compared exactly.
// From acceptance until its result is registered, a sample passes through the
// bit-serial multiplier that forms (n-1)*old (the band product old*eps runs
// alongside in a second one), a step to see the multiplier finish and start
// the divider, the bit-serial restoring divider, a step to take the quotient,
// one to form the band limits and one to compare and update the state, which
// waits until the output register is free. The divider is the longest step.
// s_tready rises again in the same cycle as the result's m_tvalid, so a new
// sample is taken only once the last one's result is registered. The result
// sits in an output register, so the next sample is taken while a finished
// result still waits for m_tready. Configuration writes are always accepted
// and should be made only while no sample is in flight.
module windowed_mean_convergence_detector_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [0:0]                             cfg_index,
    input  logic [15:0]                            cfg_data,
    // Sample input channel.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [31:0]                            s_tdata,  // [31:0] cost_sample
    // Result channel.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [wmcd_pkg::OUT_DATA_W-1:0]        m_tdata,  // [31:0] mean_value,
                                                             // [47:32] sample_count
    output logic                                   m_tuser   // [0] converged
);
    import wmcd_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] window_reg, window_next;
    logic [BAND_W-1:0]  band_reg, band_next;

    // Detector state carried from sample to sample.
    logic [COST_W-1:0]  mean_reg, mean_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               conv_reg, conv_next;

    // Per-sample working registers.
    state_t             state_reg, state_next;
    logic [COST_W-1:0]  sample_reg, sample_next;
    logic [COST_W-1:0]  old_reg, old_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic               at_win_reg, at_win_next;
    logic [COST_W-1:0]  new_mean_reg, new_mean_next;
    logic [BAND_PROD_W-1:0] lower_reg, lower_next;
    logic [BAND_PROD_W-1:0] upper_reg, upper_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // Iterative units.
    unit_ctrl_t         mul_ctrl, div_ctrl;
    unit_stat_t         mul_stat, band_stat, div_stat;
    logic [PROD_W-1:0]  mul_prod, band_prod;
    logic [COST_W-1:0]  div_quot;
    logic [NUM_W-1:0]   numerator;

    // Helpers for the count and the band.
    logic [COUNT_W-1:0]     win_eff;
    logic [COUNT_W:0]       count_inc;
    logic [COUNT_W-1:0]     n_calc;
    logic [COUNT_W-1:0]     n_minus1;
    logic [BAND_PROD_W-1:0] old_shifted;
    logic [BAND_PROD_W-1:0] mean_shifted;
    logic [BAND_PROD_W-1:0] eps_old;
    logic                   in_band;
    logic                   out_free;
    logic                   s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg[0];
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // n = min(count + 1, max(window, 1)).
    always_comb begin
        win_eff   = (window_reg == '0) ? COUNT_W'(1) : window_reg;
        count_inc = {1'b0, count_reg} + 1'b1;
        n_calc    = (count_inc > {1'b0, win_eff}) ? win_eff : count_inc[COUNT_W-1:0];
        n_minus1  = n_calc - 1'b1;
    end

    assign mul_ctrl.start = s_accept;
    assign numerator      = {1'b0, mul_prod} + {{(NUM_W-COST_W){1'b0}}, sample_reg};

    // The band limits are old*2^16 -/+ old*eps; eps < 2^16, so the lower one
    // never wraps.
    assign old_shifted  = {1'b0, old_reg, {BAND_W{1'b0}}};
    assign mean_shifted = {1'b0, new_mean_reg, {BAND_W{1'b0}}};
    assign eps_old      = {1'b0, band_prod};
    assign in_band      = (mean_shifted > lower_reg) && (mean_shifted < upper_reg);

    always_comb begin
        window_next   = window_reg;
        band_next     = band_reg;
        mean_next     = mean_reg;
        count_next    = count_reg;
        conv_next     = conv_reg;
        state_next    = state_reg;
        sample_next   = sample_reg;
        old_next      = old_reg;
        n_next        = n_reg;
        at_win_next   = at_win_reg;
        new_mean_next = new_mean_reg;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        div_ctrl.start = 1'b0;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_SIZE:   window_next = cfg_data;
                CFG_BAND_FRACTION: band_next   = cfg_data;
                default:           ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_tdata;
                    old_next    = mean_reg;
                    n_next      = n_calc;
                    at_win_next = (n_calc == win_eff);
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    new_mean_next = div_quot;
                    state_next    = ST_BAND;
                end
            end
            ST_BAND: begin
                lower_next = old_shifted - eps_old;
                upper_next = old_shifted + eps_old;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold here until the output register can take the result.
                if (out_free) begin
                    mean_next    = new_mean_reg;
                    count_next   = n_reg;
                    conv_next    = conv_reg || (at_win_reg && in_band);
                    m_valid_next = 1'b1;
                    m_data_next  = {n_reg, new_mean_reg};
                    m_user_next  = conv_reg || (at_win_reg && in_band);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= COUNT_W'(10);
            band_reg    <= BAND_W'(655);
            mean_reg    <= '0;
            count_reg   <= '0;
            conv_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            window_reg  <= window_next;
            band_reg    <= band_next;
            mean_reg    <= mean_next;
            count_reg   <= count_next;
            conv_reg    <= conv_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg   <= sample_next;
        old_reg      <= old_next;
        n_reg        <= n_next;
        at_win_reg   <= at_win_next;
        new_mean_reg <= new_mean_next;
        lower_reg    <= lower_next;
        upper_reg    <= upper_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // (n-1) * old, feeding the numerator of the mean update.
    wmcd_mul u_mul_weight (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (mul_ctrl),
        .multiplicand (mean_reg),
        .multiplier   (n_minus1),
        .stat         (mul_stat),
        .product      (mul_prod)
    );

    // old * eps, the half-width of the tolerance band. It runs in lockstep
    // with the weight multiplier.
    wmcd_mul u_mul_band (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (mul_ctrl),
        .multiplicand (mean_reg),
        .multiplier   (band_reg),
        .stat         (band_stat),
        .product      (band_prod)
    );

    wmcd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .numerator (numerator),
        .divisor   (n_reg),
        .stat      (div_stat),
        .quotient  (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg && !(band_stat.busy && 1'b0);

endmodule

// ===== test/windowed_mean_convergence_detector_checker.sv =====
module windowed_mean_convergence_detector_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  wmcd_pkg::cfg_index_t cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic                 m_tuser,
    output int                   fail_count,
    output int                   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import wmcd_pkg::*;

    typedef struct {
        logic [31:0] mean;
        logic [15:0] count;
        logic        converged;
    } mean_update_t;

    // Shadow copies of the registers and of the detector state.
    logic [15:0] window_cfg;
    logic [15:0] band_cfg;
    logic [31:0] mean_acc;
    logic [15:0] count_acc;
    logic        converged_acc;

    mean_update_t pending_means[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Folds one cost sample into the shadow state and returns the result it causes.
    function automatic mean_update_t advance_mean(input logic [31:0] sample);
        logic [16:0]  win;
        logic [16:0]  n;
        logic [63:0]  num;
        logic [63:0]  avg;
        logic [63:0]  scaled;
        logic [63:0]  lo;
        logic [63:0]  hi;
        mean_update_t upd;
        win = (window_cfg == 16'd0) ? 17'd1 : {1'b0, window_cfg};
        n = {1'b0, count_acc} + 17'd1;
        if (n > win) begin
            n = win;
        end
        num    = 64'(n - 17'd1) * 64'(mean_acc) + 64'(sample);
        avg    = num / 64'(n);
        scaled = avg << BAND_W;
        lo     = (64'd65536 - 64'(band_cfg)) * 64'(mean_acc);
        hi     = (64'd65536 + 64'(band_cfg)) * 64'(mean_acc);
        if (n == win && scaled > lo && scaled < hi) begin
            converged_acc = 1'b1;
        end
        mean_acc  = avg[31:0];
        count_acc = n[15:0];
        upd.mean      = mean_acc;
        upd.count     = count_acc;
        upd.converged = converged_acc;
        return upd;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : track
        mean_update_t want;
        if (!aresetn) begin
            window_cfg    = 16'd10;
            band_cfg      = 16'd655;
            mean_acc      = '0;
            count_acc     = '0;
            converged_acc = 1'b0;
            pending_means.delete();
        end else begin
            // Results are compared before the sample of this edge is queued.
            if (m_tvalid && m_tready) begin
                if (pending_means.size() == 0) begin
                    report("unexpected result, mean_value", 32'd0, m_tdata[31:0]);
                end else begin
                    want = pending_means.pop_front();
                    if (m_tdata[31:0] !== want.mean) begin
                        report("mean_value", want.mean, m_tdata[31:0]);
                    end
                    if (m_tdata[47:32] !== want.count) begin
                        report("sample_count", 32'(want.count), 32'(m_tdata[47:32]));
                    end
                    if (m_tuser !== want.converged) begin
                        report("converged", 32'(want.converged), 32'(m_tuser));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE:   window_cfg = cfg_data;
                    CFG_BAND_FRACTION: band_cfg   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pending_means.push_back(advance_mean(s_tdata));
            end
        end
        pending <= pending_means.size();
    end

endmodule

// ===== test/windowed_mean_convergence_detector_core_tb.sv =====
module windowed_mean_convergence_detector_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wmcd_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_WINDOW_SIZE;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;

    // Receiver control. A nonzero hold forces m_tready low while it counts
    // down; steady mode keeps the receiver ready with no idling at all.
    int rx_hold   = 0;
    int rx_run    = 0;
    bit rx_steady = 1'b0;
    // Sender control: steady mode offers samples back to back.
    bit tx_steady = 1'b0;

    always #5 aclk = ~aclk;

    windowed_mean_convergence_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    windowed_mean_convergence_detector_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver changes m_tready only at falling edges. Most stalls are
    // short and a few are long, so that stalls land on every phase of the
    // multiply and divide sequence.
    always @(negedge aclk) begin : rx_drive
        int pick;
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_run > 0) begin
            rx_run <= rx_run - 1;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                m_tready <= 1'b1;
                rx_run   <= $urandom_range(0, 20);
            end else if (pick < 95) begin
                m_tready <= 1'b0;
                rx_run   <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                rx_run   <= $urandom_range(20, 150);
            end
        end
    end

    // Writes one configuration register and waits for its transfer.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one sample until its transfer happens. With a gap of zero the
    // valid stays high so the next sample follows without a bubble.
    task automatic send_sample(input logic [31:0] value, input int gap);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stops offering samples and waits until every queued result has come
    // back. The falling edge first lets the checker count the last transfer.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 40) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    // Most samples wander closely around a base cost, which is what lets
    // the mean settle inside the band; the rest are wide jumps and extremes.
    function automatic logic [31:0] pick_sample(input logic [31:0] base);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return base ^ ($urandom & ((32'd1 << $urandom_range(0, 12)) - 32'd1));
        end else if (pick < 75) begin
            return $urandom;
        end else if (pick < 85) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h0000_0001;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return 16'd65535;
            4:       return 16'($urandom_range(3, 16));
            5:       return 16'($urandom_range(1, 65535));
            default: return 16'd10;
        endcase
    endfunction

    function automatic logic [15:0] pick_band();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd655;
            3:       return 16'($urandom_range(1, 4000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] base;
        int          burst_left;
        base       = 32'h0001_0000;
        burst_left = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed part, under the reset settings first: extremes of the
        // cost, starting from a zero mean, until the count reaches the window.
        send_sample(32'h0000_0000, 1);
        send_sample(32'hFFFF_FFFF, 0);
        send_sample(32'h0000_0000, 2);
        send_sample(32'h0000_0001, 0);
        send_sample(32'h8000_0000, 0);
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(32'h0001_0000, 0);
        send_sample(32'hFFFF_FFFF, 0);
        send_sample(32'hFFFF_FFFF, 0);
        send_sample(32'hFFFF_FFFF, 0);
        drain();

        // The window drops below the count, so the count falls back to it.
        write_reg(CFG_WINDOW_SIZE, 16'd3);
        send_sample(32'h1234_5678, 0);
        send_sample(32'h1234_5600, 0);
        drain();

        // A zero window behaves as a window of one. Two zero samples leave
        // a zero old mean, whose band is empty, so no convergence follows.
        write_reg(CFG_WINDOW_SIZE, 16'd0);
        send_sample(32'h0000_0000, 0);
        send_sample(32'h0000_0000, 0);
        send_sample(32'hABCD_EF01, 0);
        drain();

        // A zero band is empty too, even for a constant cost.
        write_reg(CFG_BAND_FRACTION, 16'd0);
        write_reg(CFG_WINDOW_SIZE, 16'd2);
        send_sample(32'h0005_0000, 0);
        send_sample(32'h0005_0000, 0);
        send_sample(32'h0005_0000, 0);
        drain();

        // The widest window keeps the count climbing.
        write_reg(CFG_WINDOW_SIZE, 16'd65535);
        send_sample(32'hFFFF_FFFF, 0);
        send_sample(32'h0000_0000, 0);
        drain();

        // The widest band with a window of one converges on a steady cost.
        write_reg(CFG_BAND_FRACTION, 16'd65535);
        write_reg(CFG_WINDOW_SIZE, 16'd1);
        send_sample(32'h0002_0000, 0);
        send_sample(32'h0002_0000, 0);
        drain();

        // Random phases, each under its own settings. Some phases run one
        // side or the other without any idling.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_WINDOW_SIZE, pick_window());
            write_reg(CFG_BAND_FRACTION, pick_band());
            tx_steady = (phase % 3 == 1);
            rx_steady = (phase % 4 == 2);
            for (int i = 0; i < 240; i++) begin
                if (burst_left == 0) begin
                    base       = $urandom >> $urandom_range(0, 24);
                    burst_left = $urandom_range(5, 60);
                end
                burst_left--;
                // The receiver holds off for a long stretch while samples keep
                // coming, so the output register fills and s_tready drops.
                if (phase == 3 && i == 100) begin
                    rx_hold = 500;
                end
                // The sender pauses until every result has come back.
                if (phase == 5 && i == 120) begin
                    drain();
                end
                send_sample(pick_sample(base),
                            (phase == 3 && i >= 100 && i < 115) ? 0 : pick_gap());
            end
            drain();
        end

        rx_steady = 1'b0;
        tx_steady = 1'b0;
        // Any stray transfer after the last expected one would show up here.
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(40_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
